/* design/uv_sphere_mesh_generator_core_macros.svh */
// Assertion macros shared by the sphere mesh generator RTL.
`ifndef UV_SPHERE_MESH_GENERATOR_CORE_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define USMG_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define USMG_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* design/usmg_pkg.sv */
// Shared types, constants and coefficient tables of the sphere mesh generator.
`default_nettype none

package usmg_pkg;

  localparam int LINE_W  = 9;   // line count registers
  localparam int ANG_W   = 31;  // unsigned angle, radians in Q3.28
  localparam int VTX_W   = 17;  // vertex index before output masking
  localparam int QF      = 28;  // fraction bits of the internal fixed point
  localparam int MAG_W   = 29;  // magnitude of a value in [0, 1.0] in Q28
  localparam int TRIG_W  = 31;  // signed sine or cosine in Q28
  localparam int KD_W    = 8;   // Taylor factorial factor
  localparam int RCP_W   = 32;  // reciprocal scale

  localparam int MAX_LINES_DEF  = 256;
  localparam int COORD_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF = 16;

  localparam int RST_LINES    = 10;
  localparam int TAYLOR_TERMS = 6;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [ANG_W-1:0] ANG_314      = 31'd842887332;
  localparam logic [ANG_W-1:0] ANG_628      = 31'd1685774664;
  localparam logic [ANG_W-1:0] HALF_PI_Q    = 31'd421657428;
  localparam logic [ANG_W-1:0] QUARTER_PI_Q = HALF_PI_Q / 2;

  localparam logic CFG_LAT_LINES  = 1'b0;
  localparam logic CFG_LONG_LINES = 1'b1;

  typedef enum logic [1:0] {
    DK_NORTH,
    DK_RING,
    DK_SOUTH,
    DK_TRI
  } desc_kind_t;

  typedef struct packed {
    desc_kind_t       kind;
    logic [ANG_W-1:0] p_ang;
    logic [ANG_W-1:0] y_ang;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic [VTX_W-1:0] c;
    logic             fin;
  } desc_t;

  // Sine series divides term n by (2n)(2n+1), cosine by (2n-1)(2n).
  function automatic logic [KD_W-1:0] sin_den(input logic [2:0] n);
    logic [KD_W-1:0] k;
    case (n)
      3'd1:    k = 8'd6;
      3'd2:    k = 8'd20;
      3'd3:    k = 8'd42;
      3'd4:    k = 8'd72;
      3'd5:    k = 8'd110;
      3'd6:    k = 8'd156;
      default: k = 8'd6;
    endcase
    return k;
  endfunction

  function automatic logic [KD_W-1:0] cos_den(input logic [2:0] n);
    logic [KD_W-1:0] k;
    case (n)
      3'd1:    k = 8'd2;
      3'd2:    k = 8'd12;
      3'd3:    k = 8'd30;
      3'd4:    k = 8'd56;
      3'd5:    k = 8'd90;
      3'd6:    k = 8'd132;
      default: k = 8'd2;
    endcase
    return k;
  endfunction

  // floor(2^32 / k) for the factors above.
  function automatic logic [RCP_W-1:0] sin_rcp(input logic [2:0] n);
    logic [RCP_W-1:0] m;
    case (n)
      3'd1:    m = 32'd715827882;
      3'd2:    m = 32'd214748364;
      3'd3:    m = 32'd102261126;
      3'd4:    m = 32'd59652323;
      3'd5:    m = 32'd39045157;
      3'd6:    m = 32'd27531841;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

  function automatic logic [RCP_W-1:0] cos_rcp(input logic [2:0] n);
    logic [RCP_W-1:0] m;
    case (n)
      3'd1:    m = 32'd2147483648;
      3'd2:    m = 32'd357913941;
      3'd3:    m = 32'd143165576;
      3'd4:    m = 32'd76695844;
      3'd5:    m = 32'd47721858;
      3'd6:    m = 32'd32537631;
      default: m = 32'd2147483648;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* design/usmg_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module usmg_div
  import usmg_pkg::*;
#(
  parameter int NUM_W = ANG_W,
  parameter int DEN_W = LINE_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign busy  = cnt_r != '0;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

/* design/usmg_front.sv */
// Front end: configuration, mesh sequencing and item descriptors.
`default_nettype none

module usmg_front
  import usmg_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire logic              in_restart,
  output logic                   in_full,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [LINE_W-1:0] cfg_data,
  output logic                   q_push,
  output desc_t                  q_data,
  input  wire logic              q_full
);

  localparam int CNT_W = $clog2(MAX_LINES);
  localparam int RST_LAT = (RST_LINES > MAX_LINES) ? MAX_LINES : RST_LINES;
  localparam longint RST_PITCH =
    (longint'(ANG_314) + longint'((RST_LAT - 1) / 2)) / longint'(RST_LAT - 1);
  localparam longint RST_YAW =
    (longint'(ANG_628) + longint'(RST_LAT / 2)) / longint'(RST_LAT);
  localparam int RST_VCOUNT = (RST_LAT - 2) * RST_LAT + 2;
  localparam int PW = LINE_W + ANG_W;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_EMIT} fstate_t;
  typedef enum logic [2:0] {PH_NORTH, PH_RING, PH_SOUTH, PH_NFAN, PH_BAND, PH_SFAN} phase_t;

  fstate_t          state_r;
  phase_t           phase_r;
  logic [LINE_W-1:0] lat_lines_r, long_lines_r;
  logic [LINE_W-1:0] lat_used_r, long_used_r;
  logic [VTX_W-1:0]  vcount_r;
  logic [ANG_W-1:0]  pitch_step_r, yaw_step_r;
  logic [CNT_W-1:0]  ring_r, col_r;
  logic              half_r, emit_after_r;

  function automatic logic [LINE_W-1:0] clamp_lines(input logic [LINE_W-1:0] v);
    logic [LINE_W-1:0] r;
    r = v;
    if (v < LINE_W'(3)) r = LINE_W'(3);
    if (v > LINE_W'(MAX_LINES)) r = LINE_W'(MAX_LINES);
    return r;
  endfunction

  logic [LINE_W-1:0] lat_c, long_c, col1, ring1;
  logic [VTX_W-1:0]  vcount_c;
  logic              acc, emit, latch_rst, wrap, latch, last_col;
  logic              div_busy_p, div_busy_y;
  logic [ANG_W-1:0]  quo_p, quo_y, num_p, num_y;
  logic [PW-1:0]     pprod, yprod;
  logic [VTX_W-1:0]  rl, a0, b0, c0, d0;

  assign lat_c    = clamp_lines(lat_lines_r);
  assign long_c   = clamp_lines(long_lines_r);
  assign vcount_c = VTX_W'(lat_c - LINE_W'(2)) * VTX_W'(long_c) + VTX_W'(2);

  assign cfg_ready = 1'b1;
  assign in_full   = (state_r != F_IDLE) || q_full;
  assign acc       = in_push && !in_full;
  assign latch_rst = (state_r == F_IDLE) && acc && in_restart;
  assign emit      = ((state_r == F_IDLE) && acc && !in_restart) ||
                     ((state_r == F_EMIT) && !q_full);
  assign col1      = LINE_W'(col_r) + LINE_W'(1);
  assign ring1     = LINE_W'(ring_r) + LINE_W'(1);
  assign last_col  = col1 >= long_used_r;
  assign wrap      = emit && (phase_r == PH_SFAN) && last_col;
  assign latch     = latch_rst || wrap;
  assign q_push    = emit;

  // Step angles: round(3.14 / (lat - 1)) and round(6.28 / long) in Q3.28.
  assign num_p = ANG_314 + ANG_W'((lat_c - LINE_W'(1)) >> 1);
  assign num_y = ANG_628 + ANG_W'(long_c >> 1);

  usmg_div #(.NUM_W(ANG_W), .DEN_W(LINE_W)) u_div_pitch (
    .clk  (clk),
    .rst_n(rst_n),
    .start(latch),
    .num  (num_p),
    .den  (lat_c - LINE_W'(1)),
    .busy (div_busy_p),
    .quo  (quo_p)
  );

  usmg_div #(.NUM_W(ANG_W), .DEN_W(LINE_W)) u_div_yaw (
    .clk  (clk),
    .rst_n(rst_n),
    .start(latch),
    .num  (num_y),
    .den  (long_c),
    .busy (div_busy_y),
    .quo  (quo_y)
  );

  assign pprod = PW'(ring1) * PW'(pitch_step_r);
  assign yprod = PW'(col_r) * PW'(yaw_step_r);
  assign rl    = VTX_W'(ring_r) * VTX_W'(long_used_r);
  assign a0    = rl + VTX_W'(col_r) + VTX_W'(1);
  assign b0    = last_col ? rl + VTX_W'(1) : a0 + VTX_W'(1);
  assign c0    = a0 + VTX_W'(long_used_r);
  assign d0    = b0 + VTX_W'(long_used_r);

  always_comb begin
    q_data = '0;
    q_data.kind = DK_TRI;
    unique case (phase_r)
      PH_NORTH: q_data.kind = DK_NORTH;
      PH_RING: begin
        q_data.kind  = DK_RING;
        q_data.p_ang = pprod[ANG_W-1:0];
        q_data.y_ang = yprod[ANG_W-1:0];
      end
      PH_SOUTH: q_data.kind = DK_SOUTH;
      PH_NFAN: begin
        q_data.b = VTX_W'(col1);
        q_data.c = last_col ? VTX_W'(1) : VTX_W'(col1) + VTX_W'(1);
      end
      PH_BAND: begin
        q_data.a = half_r ? c0 : a0;
        q_data.b = b0;
        q_data.c = half_r ? d0 : c0;
      end
      default: begin
        q_data.a   = vcount_r - VTX_W'(1);
        q_data.b   = vcount_r - VTX_W'(2) - VTX_W'(col_r);
        q_data.c   = last_col ? vcount_r - VTX_W'(2) : vcount_r - VTX_W'(3) - VTX_W'(col_r);
        q_data.fin = last_col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_lines_r  <= LINE_W'(RST_LINES);
      long_lines_r <= LINE_W'(RST_LINES);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LAT_LINES:  lat_lines_r  <= cfg_data;
        CFG_LONG_LINES: long_lines_r <= cfg_data;
        default:        lat_lines_r  <= lat_lines_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      phase_r      <= PH_NORTH;
      ring_r       <= '0;
      col_r        <= '0;
      half_r       <= 1'b0;
      emit_after_r <= 1'b0;
      lat_used_r   <= LINE_W'(RST_LAT);
      long_used_r  <= LINE_W'(RST_LAT);
      vcount_r     <= VTX_W'(RST_VCOUNT);
      pitch_step_r <= ANG_W'(RST_PITCH);
      yaw_step_r   <= ANG_W'(RST_YAW);
    end else begin
      if (emit) begin
        unique case (phase_r)
          PH_NORTH: begin
            phase_r <= PH_RING;
            ring_r  <= '0;
            col_r   <= '0;
          end
          PH_RING: begin
            if (last_col) begin
              col_r  <= '0;
              ring_r <= CNT_W'(ring1);
              if (ring1 >= lat_used_r - LINE_W'(2)) phase_r <= PH_SOUTH;
            end else begin
              col_r <= CNT_W'(col1);
            end
          end
          PH_SOUTH: begin
            phase_r <= PH_NFAN;
            col_r   <= '0;
          end
          PH_NFAN: begin
            if (last_col) begin
              col_r   <= '0;
              ring_r  <= '0;
              half_r  <= 1'b0;
              phase_r <= (lat_used_r > LINE_W'(3)) ? PH_BAND : PH_SFAN;
            end else begin
              col_r <= CNT_W'(col1);
            end
          end
          PH_BAND: begin
            half_r <= !half_r;
            if (half_r) begin
              if (last_col) begin
                col_r  <= '0;
                ring_r <= CNT_W'(ring1);
                if (ring1 >= lat_used_r - LINE_W'(3)) phase_r <= PH_SFAN;
              end else begin
                col_r <= CNT_W'(col1);
              end
            end
          end
          default: begin
            col_r <= CNT_W'(col1);
          end
        endcase
      end
      // A restart or a wrap latches the line counts and starts the step dividers.
      if (latch) begin
        lat_used_r  <= lat_c;
        long_used_r <= long_c;
        vcount_r    <= vcount_c;
        phase_r     <= PH_NORTH;
        ring_r      <= '0;
        col_r       <= '0;
        half_r      <= 1'b0;
      end
      unique case (state_r)
        F_IDLE: begin
          if (latch) begin
            state_r      <= F_DIV;
            emit_after_r <= latch_rst;
          end
        end
        F_DIV: begin
          if (!div_busy_p && !div_busy_y) begin
            pitch_step_r <= quo_p;
            yaw_step_r   <= quo_y;
            state_r      <= emit_after_r ? F_EMIT : F_IDLE;
          end
        end
        F_EMIT: begin
          if (emit) begin
            state_r      <= wrap ? F_DIV : F_IDLE;
            emit_after_r <= 1'b0;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/usmg_queue.sv */
// Short descriptor queue between the front and back ends.
`default_nettype none

module usmg_queue
  import usmg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  desc_t      wdata,
  output logic       full,
  input  wire logic  pop,
  output desc_t      rdata,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* design/usmg_sincos.sv */
// Iterative sine and cosine: quadrant reduction and a 7-term Taylor series.
`default_nettype none

module usmg_sincos
  import usmg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [ANG_W-1:0] angle,
  output logic                  busy,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_FOLD, S_SQR, S_MUL, S_RCP, S_COR, S_OUT} sstate_t;

  localparam int PROD_W = 2 * MAG_W;
  localparam int RP_W   = MAG_W + RCP_W;
  localparam int KP_W   = MAG_W + KD_W;

  sstate_t                  state_r;
  logic [ANG_W-1:0]         r_r;
  logic [1:0]               q_r;
  logic                     swap_r;
  logic [MAG_W-1:0]         x_r, x2_r, ts_r, tc_r, ps_r, pc_r, es_r, ec_r;
  logic signed [TRIG_W-1:0] as_r, ac_r, sin_r, cos_r;
  logic [2:0]               n_r;

  logic [ANG_W-1:0]  xf;
  logic [PROD_W-1:0] sq, mps, mpc;
  logic [RP_W-1:0]   rps, rpc;
  logic [KP_W-1:0]   rems, remc;
  logic [MAG_W-1:0]  tns, tnc;
  logic signed [TRIG_W-1:0] sr, cr;

  assign busy  = state_r != S_IDLE;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

  assign xf   = (r_r > QUARTER_PI_Q) ? HALF_PI_Q - r_r : r_r;
  assign sq   = PROD_W'(x_r) * PROD_W'(x_r);
  assign mps  = PROD_W'(ts_r) * PROD_W'(x2_r);
  assign mpc  = PROD_W'(tc_r) * PROD_W'(x2_r);
  assign rps  = RP_W'(ps_r) * RP_W'(sin_rcp(n_r));
  assign rpc  = RP_W'(pc_r) * RP_W'(cos_rcp(n_r));
  // The reciprocal estimate is low by at most one.
  assign rems = KP_W'(ps_r) - KP_W'(es_r) * KP_W'(sin_den(n_r));
  assign remc = KP_W'(pc_r) - KP_W'(ec_r) * KP_W'(cos_den(n_r));
  assign tns  = (rems >= KP_W'(sin_den(n_r))) ? es_r + 1'b1 : es_r;
  assign tnc  = (remc >= KP_W'(cos_den(n_r))) ? ec_r + 1'b1 : ec_r;
  assign sr   = swap_r ? ac_r : as_r;
  assign cr   = swap_r ? as_r : ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            r_r     <= angle;
            q_r     <= '0;
            state_r <= S_RED;
          end
        end
        S_RED: begin
          if (r_r >= HALF_PI_Q) begin
            r_r <= r_r - HALF_PI_Q;
            q_r <= q_r + 1'b1;
          end else begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          swap_r  <= r_r > QUARTER_PI_Q;
          x_r     <= MAG_W'(xf);
          state_r <= S_SQR;
        end
        S_SQR: begin
          x2_r    <= sq[QF +: MAG_W];
          ts_r    <= x_r;
          tc_r    <= MAG_W'(1) << QF;
          as_r    <= signed'(TRIG_W'(x_r));
          ac_r    <= signed'(TRIG_W'(1) << QF);
          n_r     <= 3'd1;
          state_r <= S_MUL;
        end
        S_MUL: begin
          ps_r    <= mps[QF +: MAG_W];
          pc_r    <= mpc[QF +: MAG_W];
          state_r <= S_RCP;
        end
        S_RCP: begin
          es_r    <= rps[RCP_W +: MAG_W];
          ec_r    <= rpc[RCP_W +: MAG_W];
          state_r <= S_COR;
        end
        S_COR: begin
          ts_r <= tns;
          tc_r <= tnc;
          if (n_r[0]) begin
            as_r <= as_r - signed'(TRIG_W'(tns));
            ac_r <= ac_r - signed'(TRIG_W'(tnc));
          end else begin
            as_r <= as_r + signed'(TRIG_W'(tns));
            ac_r <= ac_r + signed'(TRIG_W'(tnc));
          end
          if (n_r == 3'(TAYLOR_TERMS)) begin
            state_r <= S_OUT;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_OUT: begin
          case (q_r)
            2'd0: begin sin_r <= sr;  cos_r <= cr;  end
            2'd1: begin sin_r <= cr;  cos_r <= -sr; end
            2'd2: begin sin_r <= -sr; cos_r <= -cr; end
            default: begin sin_r <= -cr; cos_r <= sr; end
          endcase
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/usmg_back.sv */
// Back end: vertex positions from descriptors and the result register.
`default_nettype none

module usmg_back
  import usmg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  desc_t                       q_data,
  output logic                        q_pop,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic                        out_kind,
  output logic signed [COORD_BITS-1:0] out_pos_x,
  output logic signed [COORD_BITS-1:0] out_pos_y,
  output logic signed [COORD_BITS-1:0] out_pos_z,
  output logic [INDEX_BITS-1:0]       out_corner_a,
  output logic [INDEX_BITS-1:0]       out_corner_b,
  output logic [INDEX_BITS-1:0]       out_corner_c,
  output logic                        out_final_item
);

  localparam int FB     = COORD_BITS - 1;
  localparam int RSH    = (FB < QF) ? QF - FB : 0;
  localparam int LSH    = (FB > QF) ? FB - QF : 0;
  localparam int EXT_W  = MAG_W + LSH + 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam logic [EXT_W-1:0] RND = (RSH > 0) ? (EXT_W'(1) << (RSH - 1)) : '0;
  localparam logic [EXT_W-1:0] LIM = EXT_W'(1) << FB;

  typedef enum logic [2:0] {B_IDLE, B_PITCH, B_YAW, B_PROD, B_OUT} bstate_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W-1:0] a;
    a = (v < 0) ? -v : v;
    return MAG_W'(a);
  endfunction

  // Round half up on the magnitude, then saturate to the signed range.
  function automatic logic [COORD_BITS-1:0] to_coord(input logic neg,
                                                      input logic [MAG_W-1:0] mag);
    logic [EXT_W-1:0] m;
    m = ((EXT_W'(mag) + RND) >> RSH) << LSH;
    if (!neg && m >= LIM) m = LIM - 1'b1;
    if (neg && m > LIM) m = LIM;
    if (neg) m = -m;
    return COORD_BITS'(m);
  endfunction

  bstate_t                  state_r;
  desc_t                    desc_r;
  logic signed [TRIG_W-1:0] sp_r, cp_r;
  logic                     xneg_r, yneg_r, zneg_r, out_valid_r;
  logic [MAG_W-1:0]         xmag_r, ymag_r, zmag_r;

  logic                     sc_start, sc_busy, load;
  logic [ANG_W-1:0]         sc_angle;
  logic signed [TRIG_W-1:0] sc_sin, sc_cos;
  logic [PROD_W-1:0]        px_prod, py_prod;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign sc_start = (q_pop && (q_data.kind == DK_RING)) ||
                    ((state_r == B_PITCH) && !sc_busy);
  assign sc_angle = (state_r == B_IDLE) ? q_data.p_ang : desc_r.y_ang;
  assign load     = (state_r == B_OUT) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;

  usmg_sincos u_sincos (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sc_start),
    .angle(sc_angle),
    .busy (sc_busy),
    .sin_o(sc_sin),
    .cos_o(sc_cos)
  );

  assign px_prod = PROD_W'(mag_of(sp_r)) * PROD_W'(mag_of(sc_sin));
  assign py_prod = PROD_W'(mag_of(sp_r)) * PROD_W'(mag_of(sc_cos));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            desc_r <= q_data;
            xneg_r <= 1'b0;
            yneg_r <= 1'b0;
            xmag_r <= '0;
            ymag_r <= '0;
            zneg_r <= q_data.kind == DK_SOUTH;
            zmag_r <= ((q_data.kind == DK_NORTH) || (q_data.kind == DK_SOUTH)) ?
                      (MAG_W'(1) << QF) : '0;
            state_r <= (q_data.kind == DK_RING) ? B_PITCH : B_OUT;
          end
        end
        B_PITCH: begin
          if (!sc_busy) begin
            sp_r    <= sc_sin;
            cp_r    <= sc_cos;
            state_r <= B_YAW;
          end
        end
        B_YAW: begin
          if (!sc_busy) state_r <= B_PROD;
        end
        B_PROD: begin
          xneg_r  <= (sp_r < 0) != (sc_sin < 0);
          yneg_r  <= (sp_r < 0) == (sc_cos < 0);
          xmag_r  <= px_prod[QF +: MAG_W];
          ymag_r  <= py_prod[QF +: MAG_W];
          zneg_r  <= cp_r < 0;
          zmag_r  <= mag_of(cp_r);
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (load) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind       <= desc_r.kind == DK_TRI;
      out_pos_x      <= to_coord(xneg_r, xmag_r);
      out_pos_y      <= to_coord(yneg_r, ymag_r);
      out_pos_z      <= to_coord(zneg_r, zmag_r);
      out_corner_a   <= INDEX_BITS'(desc_r.a);
      out_corner_b   <= INDEX_BITS'(desc_r.b);
      out_corner_c   <= INDEX_BITS'(desc_r.c);
      out_final_item <= desc_r.fin;
    end
  end

endmodule

`default_nettype wire

/* design/uv_sphere_mesh_generator_core.sv */
// Top level of the UV sphere mesh generator.
//
// Every input beat on the in_ channel yields exactly one result beat: the next
// vertex or triangle of a UV sphere. in_restart high starts over at the north
// pole, latching the line counts; otherwise the stream advances one item and
// wraps to the north pole after the final south fan triangle.
// Results come out through a queue-like port: while out_empty is low the
// oldest result sits on the out_ ports, and out_pop takes it. A stalled
// receiver only fills the result register and the descriptor queue; the
// input then shows in_full until space frees up.
// A pole or a triangle passes through the descriptor queue and the back end's
// B_OUT state into the result register. A ring vertex runs the shared
// sine/cosine unit twice, first for the pitch and then for the yaw. A restart
// or a wrap also waits for the bit-serial dividers that form the steps.
// Configuration writes (cfg_index 0: latitude lines, 1: longitude lines) are
// always ready and take effect only at the next restart or wrap.
// Reset is synchronous and active low; it loads ten latitude and ten
// longitude lines and points the stream at the north pole.
`default_nettype none
`include "uv_sphere_mesh_generator_core_macros.svh"

module uv_sphere_mesh_generator_core
  import usmg_pkg::*;
#(
  parameter int MAX_LINES  = MAX_LINES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_push,
  input  wire logic                    in_restart,
  output logic                         in_full,
  output logic                         out_empty,
  input  wire logic                    out_pop,
  output logic                         out_kind,
  output logic signed [COORD_BITS-1:0] out_pos_x,
  output logic signed [COORD_BITS-1:0] out_pos_y,
  output logic signed [COORD_BITS-1:0] out_pos_z,
  output logic [INDEX_BITS-1:0]        out_corner_a,
  output logic [INDEX_BITS-1:0]        out_corner_b,
  output logic [INDEX_BITS-1:0]        out_corner_c,
  output logic                         out_final_item,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [LINE_W-1:0]       cfg_data
);

  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_wdata, q_rdata;

  // The front end walks the mesh order and describes each item.
  usmg_front #(.MAX_LINES(MAX_LINES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_restart(in_restart),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // Descriptors wait here while the back end evaluates a vertex.
  usmg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // The back end computes positions and holds the result beat.
  usmg_back #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_kind      (out_kind),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .out_corner_a  (out_corner_a),
    .out_corner_b  (out_corner_b),
    .out_corner_c  (out_corner_c),
    .out_final_item(out_final_item)
  );

  // The front never pushes into a full queue, and the back never pops an empty one.
  `USMG_ASSERT_IMP(a_push_room, clk, rst_n, q_push, !q_full)
  `USMG_ASSERT_IMP(a_pop_data, clk, rst_n, q_pop, !q_empty)
  // Only a triangle can close the sphere.
  `USMG_ASSERT_IMP(a_final_tri, clk, rst_n, !out_empty && out_final_item, out_kind)
  // A restart keeps the input closed while the step angles are computed.
  `USMG_ASSERT_NXT(a_restart_busy, clk, rst_n, in_push && !in_full && in_restart, in_full)

endmodule

`default_nettype wire
